// ----- rtl/core/mtc_pkg.sv -----
// morse text codec package: item types, character constants and code tables
// used by mtc_step and morse_text_codec_unit; no dependencies
package mtc_pkg;

  localparam int RunMax = 7;
  localparam int MaxSymbols = 4;

  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_DASH  = 8'h5f;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7a;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5a;
  localparam logic [7:0] CASE_GAP   = 8'd32;

  localparam logic [RunMax-1:0][7:0] SPACE_TEXT = {
    8'h5d, 8'h65, 8'h63, 8'h61, 8'h70, 8'h73, 8'h5b
  };

  localparam logic [2:0] REG_DIRECTION = 3'd0;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  typedef struct packed {
    logic [4:0] node;
    logic [2:0] symbols;
    logic       bad;
  } token_t;

  typedef struct packed {
    logic [2:0]              count;
    logic [RunMax-1:0][7:0]  bytes;
  } run_t;

  // letter held at each heap node of the code tree, zero where unused
  function automatic logic [7:0] tree_letter(input logic [4:0] node);
    logic [7:0] l;
    unique case (node)
      5'd1:  l = "E";
      5'd2:  l = "T";
      5'd3:  l = "I";
      5'd4:  l = "A";
      5'd5:  l = "N";
      5'd6:  l = "M";
      5'd7:  l = "S";
      5'd8:  l = "U";
      5'd9:  l = "R";
      5'd10: l = "W";
      5'd11: l = "D";
      5'd12: l = "K";
      5'd13: l = "G";
      5'd14: l = "O";
      5'd15: l = "H";
      5'd16: l = "V";
      5'd17: l = "F";
      5'd19: l = "L";
      5'd21: l = "P";
      5'd22: l = "J";
      5'd23: l = "B";
      5'd24: l = "X";
      5'd25: l = "C";
      5'd26: l = "Y";
      5'd27: l = "Z";
      5'd28: l = "Q";
      default: l = 8'h00;
    endcase
    return l;
  endfunction

  // heap index plus one for letters A to Z: leading one then dash bits
  function automatic logic [4:0] letter_code(input logic [4:0] idx);
    logic [4:0] h;
    unique case (idx)
      5'd0:  h = 5'd5;
      5'd1:  h = 5'd24;
      5'd2:  h = 5'd26;
      5'd3:  h = 5'd12;
      5'd4:  h = 5'd2;
      5'd5:  h = 5'd18;
      5'd6:  h = 5'd14;
      5'd7:  h = 5'd16;
      5'd8:  h = 5'd4;
      5'd9:  h = 5'd23;
      5'd10: h = 5'd13;
      5'd11: h = 5'd20;
      5'd12: h = 5'd7;
      5'd13: h = 5'd6;
      5'd14: h = 5'd15;
      5'd15: h = 5'd22;
      5'd16: h = 5'd29;
      5'd17: h = 5'd10;
      5'd18: h = 5'd8;
      5'd19: h = 5'd3;
      5'd20: h = 5'd9;
      5'd21: h = 5'd17;
      5'd22: h = 5'd11;
      5'd23: h = 5'd25;
      5'd24: h = 5'd27;
      5'd25: h = 5'd28;
      default: h = 5'd0;
    endcase
    return h;
  endfunction

endpackage

// ----- rtl/core/mtc_step.sv -----
// morse text codec item logic: one input byte to a run of result bytes
// and the next token state; uses mtc_pkg
module mtc_step (
  input  logic            direction,
  input  logic [7:0]      in_char,
  input  logic            end_of_line,
  input  mtc_pkg::token_t tok,
  output mtc_pkg::token_t tok_next,
  output mtc_pkg::run_t   run
);
  import mtc_pkg::*;

  logic [7:0] upper;
  logic [7:0] letter_off;
  logic [4:0] code;
  logic [2:0] depth;
  logic [4:0] code_sh;
  token_t     tok_sym;
  logic       sym_branch;
  logic       is_sym;
  logic       ok_cur;
  logic       ok_sym;
  logic [7:0] let_cur;
  logic [7:0] let_sym;

  assign upper = (in_char >= CHAR_LC_A && in_char <= CHAR_LC_Z) ? in_char - CASE_GAP : in_char;
  assign letter_off = upper - CHAR_UC_A;
  assign code = letter_code(letter_off[4:0]);

  always_comb begin
    priority if (code[4]) depth = 3'd4;
    else if (code[3]) depth = 3'd3;
    else if (code[2]) depth = 3'd2;
    else depth = 3'd1;
  end

  // symbol step of the token
  assign is_sym = (in_char == CHAR_DOT) || (in_char == CHAR_DASH);
  assign sym_branch = (in_char == CHAR_DASH);

  always_comb begin
    tok_sym = tok;
    if (is_sym) begin
      if (!tok.bad) begin
        if (tok.symbols >= 3'(MaxSymbols)) begin
          tok_sym.bad = 1'b1;
        end else begin
          tok_sym.node = {tok.node[3:0], 1'b0} + (sym_branch ? 5'd2 : 5'd1);
          tok_sym.symbols = tok.symbols + 3'd1;
        end
      end
    end else if (in_char != CHAR_SPACE) begin
      tok_sym.bad = 1'b1;
    end
  end

  assign let_cur = tree_letter(tok.node);
  assign let_sym = tree_letter(tok_sym.node);
  assign ok_cur = !tok.bad && tok.symbols != 3'd0 && let_cur != 8'h00;
  assign ok_sym = !tok_sym.bad && tok_sym.symbols != 3'd0 && let_sym != 8'h00;

  always_comb begin
    run = '0;
    tok_next = tok;
    code_sh = '0;
    if (direction == DIR_ENCODE) begin
      if (upper == CHAR_SPACE || upper == CHAR_TAB) begin
        run.count = 3'(RunMax);
        run.bytes = SPACE_TEXT;
      end else if (upper >= CHAR_UC_A && upper <= CHAR_UC_Z) begin
        run.count = depth;
        for (int j = 0; j < MaxSymbols; j++) begin
          if (3'(j) < depth) begin
            code_sh = code >> (depth - 3'(j) - 3'd1);
            run.bytes[j] = code_sh[0] ? CHAR_DASH : CHAR_DOT;
          end
        end
      end
    end else begin
      if (in_char == CHAR_SPACE) begin
        tok_next = '0;
        if (ok_cur) begin
          run.count = 3'd1;
          run.bytes[0] = let_cur;
        end
      end else begin
        tok_next = tok_sym;
        if (end_of_line) begin
          tok_next = '0;
          if (ok_sym) begin
            run.count = 3'd1;
            run.bytes[0] = let_sym;
          end
        end
      end
      if (end_of_line) begin
        tok_next = '0;
      end
    end
  end

endmodule

// ----- rtl/core/morse_text_codec_unit.sv -----
// morse text codec top level: item channels, run register and config port
// depends on mtc_pkg and mtc_step
//
// in_valid/in_ready take one text byte per item with its end_of_line flag.
// out_valid/out_ready give the result bytes with last_of_run on the final
// byte that an item causes. the direction register (address 0 of the apb
// port) selects encode (0) or decode (1); change it only while idle.
// an accepted item is worked out in the cycle it is taken and its bytes
// are loaded into the run register, so the first result byte appears in
// the next cycle. the run register shifts out one byte per cycle while
// out_ready is high and holds while it is low. an item with 1 to 7 result
// bytes (seven for a space or tab in encode mode) holds the input, with
// in_ready low, until its last byte leaves; a new item is taken in the
// cycle the last byte leaves. an item with no bytes leaves in_ready high.
// reset clears the run, the pending token and direction.
module morse_text_codec_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        end_of_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mtc_pkg::*;

  logic                   direction;
  token_t                 tok;
  token_t                 tok_next;
  run_t                   step_run;
  logic                   run_valid;
  logic [RunMax-1:0][7:0] run_bytes;
  logic [2:0]             run_left;
  logic                   in_fire;
  logic                   out_fire;
  logic                   run_done;

  mtc_step u_step (
    .direction   (direction),
    .in_char     (in_char),
    .end_of_line (end_of_line),
    .tok         (tok),
    .tok_next    (tok_next),
    .run         (step_run)
  );

  assign run_done = run_left == 3'd1;
  assign in_ready = !run_valid || (out_ready && run_done);
  assign in_fire = in_valid && in_ready;
  assign out_fire = run_valid && out_ready;

  assign out_valid = run_valid;
  assign out_char = run_bytes[0];
  assign last_of_run = run_done;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_DIRECTION) ? {31'd0, direction} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
    end else if (psel && penable && pwrite && paddr[2] == REG_DIRECTION[2]) begin
      direction <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else if (in_fire) begin
      tok <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      run_left <= '0;
    end else begin
      if (out_fire) begin
        run_left <= run_left - 3'd1;
        if (run_done) begin
          run_valid <= 1'b0;
        end
      end
      if (in_fire && step_run.count != 3'd0) begin
        run_valid <= 1'b1;
        run_left <= step_run.count;
      end
    end
  end

  // result bytes, shifted down as they leave
  always_ff @(posedge clk) begin
    if (in_fire && step_run.count != 3'd0) begin
      run_bytes <= step_run.bytes;
    end else if (out_fire) begin
      run_bytes <= {8'h00, run_bytes[RunMax-1:1]};
    end
  end

endmodule

// ----- test/morse_text_codec_unit_tb.sv -----
// self-checking bench for morse_text_codec_unit: encode and decode traffic,
// direction writes over the apb port, random stalls on both item channels
// depends on mtc_pkg and the morse_text_codec_unit rtl
`timescale 1ns / 100ps

module morse_text_codec_unit_tb;
  import mtc_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_byte_t;

  // letters at each heap node of the code tree, '*' where no letter sits
  localparam logic [8*31-1:0] TREE_TEXT = "*ETIANMSURWDKGOHVF*L*PJBXCYZQ**";
  localparam logic [8*7-1:0] SPACE_RUN = "[space]";
  localparam logic [7:0] NO_LETTER = "*";
  localparam logic [2:0] ADDR_DIRECTION = 3'(4 * REG_DIRECTION);
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char;
  logic        end_of_line;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_char;
  logic        last_of_run;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dir_t       cur_dir;
  logic [4:0] tok_node;
  logic [2:0] tok_syms;
  logic       tok_bad;

  out_byte_t pending_bytes[$];
  int send_idle_pct = 12;
  int recv_idle_pct = 88;
  int items_sent = 0;
  int bytes_checked = 0;
  int err_count = 0;

  morse_text_codec_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_char(in_char),
    .end_of_line(end_of_line),
    .out_valid(out_valid), .out_ready(out_ready), .out_char(out_char),
    .last_of_run(last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] tree_at(input int node);
    return TREE_TEXT[8*(30-node) +: 8];
  endfunction

  function automatic void spell_morse(input logic [7:0] letter, output logic [7:0] syms[$]);
    int idx;
    int h;
    int depth;
    syms = {};
    idx = 0;
    depth = 0;
    if (letter < CHAR_UC_A || letter > CHAR_UC_Z) return;
    for (int n = 1; n < 31; n++) begin
      if (tree_at(n) == letter) idx = n;
    end
    h = idx + 1;
    while ((h >> (depth + 1)) != 0) depth++;
    for (int k = depth; k > 0; k--) begin
      syms.push_back(((h >> (k - 1)) & 1) ? CHAR_DASH : CHAR_DOT);
    end
  endfunction

  function automatic void clear_token();
    tok_node = '0;
    tok_syms = '0;
    tok_bad = 1'b0;
  endfunction

  function automatic void add_symbol(input logic [4:0] branch);
    if (tok_bad) return;
    if (tok_syms >= 3'(MaxSymbols)) begin
      tok_bad = 1'b1;
      return;
    end
    tok_node = 5'(2 * tok_node + branch);
    tok_syms = tok_syms + 3'd1;
  endfunction

  function automatic int flush_letter();
    logic [7:0] letter;
    out_byte_t ob;
    int n;
    n = 0;
    letter = tree_at(tok_node % 31);
    if (!tok_bad && tok_syms > 0 && letter != NO_LETTER) begin
      ob.ch = letter;
      ob.last = 1'b1;
      pending_bytes.push_back(ob);
      n = 1;
    end
    clear_token();
    return n;
  endfunction

  // works out the bytes one text item gives and queues them
  function automatic int codec_predict(input logic [7:0] c, input logic eol);
    logic [7:0] syms[$];
    logic [7:0] u;
    out_byte_t ob;
    int n;
    n = 0;
    if (cur_dir == DIR_ENCODE) begin
      u = (c >= CHAR_LC_A && c <= CHAR_LC_Z) ? c - CASE_GAP : c;
      if (u == CHAR_SPACE || u == CHAR_TAB) begin
        for (int i = 0; i < 7; i++) begin
          ob.ch = SPACE_RUN[8*(6-i) +: 8];
          ob.last = (i == 6);
          pending_bytes.push_back(ob);
        end
        n = 7;
      end else begin
        spell_morse(u, syms);
        n = syms.size();
        for (int i = 0; i < n; i++) begin
          ob.ch = syms[i];
          ob.last = (i == n - 1);
          pending_bytes.push_back(ob);
        end
      end
    end else begin
      if (c == CHAR_DOT) add_symbol(5'd1);
      else if (c == CHAR_DASH) add_symbol(5'd2);
      else if (c == CHAR_SPACE) n = flush_letter();
      else tok_bad = 1'b1;
      if (eol && n == 0) n = flush_letter();
      else if (eol) clear_token();
    end
    return n;
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic eol);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char <= c;
    end_of_line <= eol;
    do @(posedge clk); while (!in_ready);
    void'(codec_predict(c, eol));
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic eol_last);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], eol_last && i == s.len() - 1);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_DIRECTION) cur_dir = dir_t'(data[0]);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_encode();
    write_reg(ADDR_DIRECTION, 32'h0000_0000);
    send_byte("a", 1'b0);
    send_byte("Z", 1'b1);
    send_byte(CHAR_SPACE, 1'b0);
    send_byte(CHAR_TAB, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte("-", 1'b0);
    wait_idle();
  endtask

  task automatic test_decode();
    write_reg(ADDR_DIRECTION, 32'hffff_ffff);
    send_text(". ", 1'b0);
    send_text("_", 1'b1);
    send_text(" ", 1'b1);
    send_text("..... ", 1'b0);
    send_byte(CHAR_DOT, 1'b0);
    send_byte(CHAR_TAB, 1'b0);
    send_byte(CHAR_SPACE, 1'b0);
    send_text("..__ ", 1'b0);
    send_text("__..", 1'b1);
    wait_idle();
  endtask

  // pending token survives encode items and writes to an unused address
  task automatic test_direction_change();
    write_reg(ADDR_DIRECTION, 32'h0000_0001);
    send_text("._", 1'b0);
    wait_idle();
    write_reg(ADDR_DIRECTION, 32'hffff_fffe);
    send_byte("k", 1'b0);
    wait_idle();
    write_reg(ADDR_UNUSED, 32'hffff_ffff);
    send_byte("e", 1'b0);
    wait_idle();
    write_reg(ADDR_DIRECTION, 32'h0000_0001);
    send_byte(CHAR_SPACE, 1'b0);
    wait_idle();
  endtask

  task automatic send_random_text();
    int r;
    logic [7:0] c;
    r = $urandom_range(99);
    if (r < 50) c = 8'($urandom_range(25)) + ($urandom_range(1) ? CHAR_UC_A : CHAR_LC_A);
    else if (r < 65) c = $urandom_range(1) ? CHAR_SPACE : CHAR_TAB;
    else c = 8'($urandom_range(255));
    send_byte(c, 1'($urandom_range(1)));
  endtask

  task automatic send_random_token();
    int r;
    int len;
    logic [7:0] syms[$];
    r = $urandom_range(99);
    if (r < 60) begin
      spell_morse(8'($urandom_range(25)) + CHAR_UC_A, syms);
      if ($urandom_range(4) == 0) begin
        for (int i = 0; i < syms.size(); i++) send_byte(syms[i], i == syms.size() - 1);
      end else begin
        foreach (syms[i]) send_byte(syms[i], 1'b0);
        repeat ($urandom_range(1, 2)) send_byte(CHAR_SPACE, $urandom_range(9) == 0);
      end
    end else if (r < 75) begin
      len = $urandom_range(6);
      repeat (len) send_byte($urandom_range(1) ? CHAR_DASH : CHAR_DOT, 1'b0);
      send_byte(CHAR_SPACE, 1'($urandom_range(1)));
    end else if (r < 85) begin
      send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    end else begin
      len = $urandom_range(1, 3);
      repeat (len) send_byte($urandom_range(1) ? CHAR_DASH : CHAR_DOT, 1'b0);
      send_byte($urandom_range(1) ? CHAR_TAB : 8'($urandom_range(255)), 1'b0);
      send_byte(CHAR_SPACE, 1'b0);
    end
  endtask

  task automatic test_random_traffic();
    int target;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 88 : 0;
      recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 12 : 0;
      wait_idle();
      write_reg(ADDR_DIRECTION, $urandom());
      target = items_sent + 133;
      while (items_sent < target) begin
        if ($urandom_range(39) == 0) begin
          wait_idle();
          write_reg(ADDR_DIRECTION, $urandom());
        end
        if (cur_dir == DIR_ENCODE) send_random_text();
        else send_random_token();
      end
    end
    wait_idle();
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    out_byte_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected result byte %h", out_char);
        err_count++;
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (out_char !== want.ch) begin
          $error("out_char: expected %h, got %h", want.ch, out_char);
          err_count++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, last_of_run);
          err_count++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_char = '0;
    end_of_line = 1'b0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cur_dir = DIR_ENCODE;
    clear_token();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_encode();
    test_decode();
    test_direction_change();
    test_random_traffic();
    $display("checked %0d result bytes from %0d text items", bytes_checked, items_sent);
    $display("both directions, token edge cases and three stall patterns exercised");
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
